@@ rtl/srwr_pkg.sv @@
// Shared types and constants for the selective-repeat window receiver.
`default_nettype none

package srwr_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 11;
    localparam int OUT_TAG_W   = 16;
    localparam int WIN_W       = 6;

    localparam logic [LEN_W-1:0] PAYLOAD_MAX = LEN_W'(1461);

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [SEQ_W-1:0]      seq_num;
        logic [LEN_W-1:0]      pay_length;
        logic                  checksum_ok;
        logic [OUT_TAG_W-1:0]  payload_tag;
    } t_in_word;

    typedef struct packed {
        logic                  kind;
        logic [SEQ_W-1:0]      out_seq;
        logic [LEN_W-1:0]      out_length;
        logic [OUT_TAG_W-1:0]  out_tag;
        logic                  last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic evaluate;
        logic store;
        logic close;
        logic deliver;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_end;
        logic accept;
        logic out_empty;
        logic head_valid;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/srwr_ctrl.sv @@
// Sequencing state machine for the selective-repeat window receiver.
`default_nettype none

module srwr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire srwr_pkg::t_sts i_sts,
    output srwr_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SLOT = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.is_end) begin
                    o_cmd.close = 1'b1;
                    n_state     = ST_WAIT;
                end else begin
                    o_cmd.evaluate = 1'b1;
                    n_state        = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (i_sts.accept) begin
                    o_cmd.store = 1'b1;
                    n_state     = ST_WAIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT: begin
                // release one slot per free output register, stop at a hole
                if (i_sts.out_empty) begin
                    if (i_sts.head_valid) begin
                        o_cmd.deliver = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srwr_dp.sv @@
// Datapath: window registers, slot store, valid bits and output register.
`default_nettype none

module srwr_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire srwr_pkg::t_in_word          i_in,
    output srwr_pkg::t_out_word              o_out,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_cfg_valid,
    input  wire logic [srwr_pkg::WIN_W-1:0]  i_cfg_data,
    input  wire srwr_pkg::t_cmd              i_cmd,
    output srwr_pkg::t_sts                   o_sts
);

    localparam int MEM_W = srwr_pkg::LEN_W + srwr_pkg::TAG_BITS;

    srwr_pkg::t_in_word                 r_in;
    logic [srwr_pkg::WIN_W-1:0]         r_win_cfg;
    logic [srwr_pkg::SEQ_W-1:0]         r_base;
    logic [srwr_pkg::IDX_W-1:0]         r_head;
    logic [srwr_pkg::WINDOW_MAX-1:0]    r_valid;
    logic [srwr_pkg::IDX_W-1:0]         r_off;
    logic                               r_pass;
    srwr_pkg::t_out_word                r_out;
    logic                               r_out_valid;
    logic [MEM_W-1:0]                   r_mem [srwr_pkg::WINDOW_MAX];
    logic [MEM_W-1:0]                   r_rd;

    logic [srwr_pkg::WIN_W-1:0]         win;
    logic [srwr_pkg::SEQ_W-1:0]         off;
    logic [srwr_pkg::IDX_W:0]           phys_sum;
    logic [srwr_pkg::IDX_W-1:0]         phys;
    logic [srwr_pkg::IDX_W-1:0]         head_nxt;

    // clamp the window to 1..WINDOW_MAX
    always_comb begin
        if (r_win_cfg == '0) begin
            win = srwr_pkg::WIN_W'(1);
        end else if (r_win_cfg > srwr_pkg::WIN_W'(srwr_pkg::WINDOW_MAX)) begin
            win = srwr_pkg::WIN_W'(srwr_pkg::WINDOW_MAX);
        end else begin
            win = r_win_cfg;
        end
    end

    assign off      = r_in.seq_num - r_base;
    assign phys_sum = {1'b0, r_head} + {1'b0, r_off};
    assign phys     = (phys_sum >= (srwr_pkg::IDX_W+1)'(srwr_pkg::WINDOW_MAX))
                    ? srwr_pkg::IDX_W'(phys_sum - (srwr_pkg::IDX_W+1)'(srwr_pkg::WINDOW_MAX))
                    : phys_sum[srwr_pkg::IDX_W-1:0];
    assign head_nxt = (r_head == srwr_pkg::IDX_W'(srwr_pkg::WINDOW_MAX - 1))
                    ? '0 : r_head + srwr_pkg::IDX_W'(1);

    assign o_sts.is_end     = (r_in.req_type == srwr_pkg::REQ_END);
    assign o_sts.accept     = r_pass & ~r_valid[phys];
    assign o_sts.out_empty  = ~r_out_valid;
    assign o_sts.head_valid = r_valid[r_head];

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.evaluate) begin
            r_off  <= off[srwr_pkg::IDX_W-1:0];
            r_pass <= r_in.checksum_ok
                    & (r_in.pay_length <= srwr_pkg::PAYLOAD_MAX)
                    & (off < srwr_pkg::SEQ_W'(win));
        end
        if (i_cmd.store) begin
            r_out.kind       <= srwr_pkg::KIND_ACK;
            r_out.out_seq    <= r_in.seq_num;
            r_out.out_length <= '0;
            r_out.out_tag    <= '0;
            r_out.last       <= (r_off != '0);
        end else if (i_cmd.close) begin
            r_out.kind       <= srwr_pkg::KIND_ACK;
            r_out.out_seq    <= r_in.seq_num;
            r_out.out_length <= '0;
            r_out.out_tag    <= '0;
            r_out.last       <= 1'b1;
        end else if (i_cmd.deliver) begin
            r_out.kind       <= srwr_pkg::KIND_DELIVER;
            r_out.out_seq    <= r_base;
            r_out.out_length <= r_rd[MEM_W-1 -: srwr_pkg::LEN_W];
            r_out.out_tag    <= srwr_pkg::OUT_TAG_W'(r_rd[srwr_pkg::TAG_BITS-1:0]);
            r_out.last       <= ~r_valid[head_nxt];
        end
    end

    // slot store: one write port, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[phys] <= {r_in.pay_length, r_in.payload_tag[srwr_pkg::TAG_BITS-1:0]};
        end
        r_rd <= r_mem[r_head];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg   <= srwr_pkg::WIN_W'(32);
            r_base      <= '0;
            r_head      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win_cfg <= i_cfg_data;
            end
            if (i_cmd.store || i_cmd.close || i_cmd.deliver) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.close) begin
                r_valid <= '0;
                r_base  <= '0;
                r_head  <= '0;
            end else if (i_cmd.store) begin
                r_valid[phys] <= 1'b1;
            end else if (i_cmd.deliver) begin
                r_valid[r_head] <= 1'b0;
                r_head          <= head_nxt;
                r_base          <= r_base + srwr_pkg::SEQ_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/selective_repeat_window_receiver_top.sv @@
// Top level of the selective-repeat window receiver.
//
// Receive-side reorder engine for a sliding-window transport. Each input word is
// one packet header. A DATA header with a good checksum, length up to 1461 and a
// sequence number inside [base, base + window) whose slot is still free gets an
// acknowledgement word (kind 0) and is stored; then every stored slot from the
// base onward goes out in order as delivery words (kind 1) and the base advances.
// Corrupt, oversized, duplicate, below-base and beyond-window DATA headers are
// dropped with no output. An END header is acknowledged and then clears all
// slots and sets the base back to zero. The last output word of each header has
// last set. Sequencing: a header is captured while idle and then checked in the
// evaluate and slot states (offset subtract and window compare, then slot lookup);
// a dropped header then returns the block to idle. Each result word goes through
// a single output register; the in-order walk reads one slot per word from the
// slot store's registered read port, and each delivery waits until the previous
// word has left the output register. The input is accepted only once all words
// of the previous header have left. The window register (6 bits, reset 32,
// clamped to 1..32) is always ready to take a write; write it only while the block is idle.
`default_nettype none

module selective_repeat_window_receiver_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire srwr_pkg::t_in_word          i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output srwr_pkg::t_out_word              o_out,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [srwr_pkg::WIN_W-1:0]  i_cfg_data
);

    srwr_pkg::t_cmd cmd;
    srwr_pkg::t_sts sts;

    // window register takes a write at any time
    assign o_cfg_ready = 1'b1;

    srwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srwr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

@@ tb/srwr_checker.sv @@
// Checker for the window receiver: tracks the window, predicts output words, compares.
`timescale 1ns / 100ps

module srwr_checker
    import srwr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_in_word         i_in,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_out_word        i_out,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [WIN_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_hdr_count,
    output int                    o_ack_count,
    output int                    o_dlv_count,
    output int                    o_peak_burst
);

    logic [SEQ_W-1:0]      rx_base;
    logic [WINDOW_MAX-1:0] slot_held;
    logic [LEN_W-1:0]      slot_len [WINDOW_MAX];
    logic [OUT_TAG_W-1:0]  slot_tag [WINDOW_MAX];
    logic [WIN_W-1:0]      window_reg;
    t_out_word             owed_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_hdr_count  = 0;
        o_ack_count  = 0;
        o_dlv_count  = 0;
        o_peak_burst = 0;
    end

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= 40) begin
            $display("[%0t] MISMATCH %s", $realtime, what);
        end
    endtask

    function automatic t_out_word make_word(input logic kind, input logic [SEQ_W-1:0] seq,
                                            input logic [LEN_W-1:0] len,
                                            input logic [OUT_TAG_W-1:0] tag);
        t_out_word w;
        w.kind       = kind;
        w.out_seq    = seq;
        w.out_length = len;
        w.out_tag    = tag;
        w.last       = 1'b0;
        return w;
    endfunction

    // Apply one header to the window and queue the words it owes.
    function automatic void take_header(input t_in_word hdr);
        t_out_word            burst [$];
        logic [SEQ_W-1:0]     offset;
        logic [IDX_W-1:0]     slot;
        logic [OUT_TAG_W-1:0] tag_keep;
        int                   win;
        int                   run;
        int                   i;
        tag_keep = OUT_TAG_W'((64'd1 << TAG_BITS) - 64'd1);
        if (hdr.req_type == REQ_END) begin
            burst.push_back(make_word(KIND_ACK, hdr.seq_num, '0, '0));
            rx_base   = '0;
            slot_held = '0;
        end else begin
            win = int'(window_reg);
            if (win < 1) win = 1;
            if (win > WINDOW_MAX) win = WINDOW_MAX;
            offset = hdr.seq_num - rx_base;
            slot   = offset[IDX_W-1:0];
            if (hdr.checksum_ok && hdr.pay_length <= PAYLOAD_MAX
                    && offset < SEQ_W'(win) && !slot_held[slot]) begin
                slot_held[slot] = 1'b1;
                slot_len[slot]  = hdr.pay_length;
                slot_tag[slot]  = hdr.payload_tag & tag_keep;
                burst.push_back(make_word(KIND_ACK, hdr.seq_num, '0, '0));
                run = 0;
                while (run < WINDOW_MAX && slot_held[run]) begin
                    burst.push_back(make_word(KIND_DELIVER, rx_base + SEQ_W'(run),
                                              slot_len[run], slot_tag[run]));
                    run++;
                end
                // slide the window down past the released run
                if (run > 0) begin
                    for (i = 0; i < WINDOW_MAX; i++) begin
                        if (i + run < WINDOW_MAX) begin
                            slot_held[i] = slot_held[i + run];
                            slot_len[i]  = slot_len[i + run];
                            slot_tag[i]  = slot_tag[i + run];
                        end else begin
                            slot_held[i] = 1'b0;
                        end
                    end
                    rx_base = rx_base + SEQ_W'(run);
                end
            end
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
            if (burst.size() > o_peak_burst) o_peak_burst = burst.size();
            foreach (burst[k]) begin
                if (burst[k].kind == KIND_ACK) o_ack_count++;
                else o_dlv_count++;
                owed_words.push_back(burst[k]);
            end
        end
    endfunction

    task automatic compare_field(input string name, input logic [SEQ_W-1:0] got,
                                 input logic [SEQ_W-1:0] want, input logic [SEQ_W-1:0] at_seq);
        if (got !== want) begin
            report_mismatch($sformatf("word for seq %0d: %s is %0h, expected %0h",
                                      at_seq, name, got, want));
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (owed_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d seq %0d", got.kind, got.out_seq));
        end else begin
            want = owed_words.pop_front();
            compare_field("kind", SEQ_W'(got.kind), SEQ_W'(want.kind), want.out_seq);
            compare_field("seq", got.out_seq, want.out_seq, want.out_seq);
            compare_field("length", SEQ_W'(got.out_length), SEQ_W'(want.out_length),
                          want.out_seq);
            compare_field("tag", SEQ_W'(got.out_tag), SEQ_W'(want.out_tag), want.out_seq);
            compare_field("last", SEQ_W'(got.last), SEQ_W'(want.last), want.out_seq);
        end
    endtask

    // Retire output words before predicting from a header taken on the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_base    = '0;
            slot_held  = '0;
            window_reg = WIN_W'(WINDOW_MAX);
            owed_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) window_reg = i_cfg_data;
            if (i_out_valid && i_out_ready) check_word(i_out);
            if (i_in_valid && i_in_ready) begin
                o_hdr_count++;
                take_header(i_in);
            end
        end
        o_pending <= owed_words.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, header stimulus in phases, and the final verdict.
`timescale 1ns / 100ps

module tb;
    import srwr_pkg::*;

    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake on any channel
    localparam int HOLD_CYCLES   = 250;   // long output hold-off
    localparam int SETTLE_CYCLES = 8;     // a dropped header keeps the block busy with no word owed
    localparam int PHASE_ITEMS   = 45;

    typedef enum {ORDER_SHUFFLE, ORDER_UP, ORDER_DOWN} t_order;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_word         i_in;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_word        o_out;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [WIN_W-1:0] i_cfg_data;

    int fail_count;
    int pending_words;
    int hdr_count;
    int ack_count;
    int dlv_count;
    int peak_burst;

    // Stimulus knobs; the last two are shared with the output-side process.
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_requests = 0;

    // Sequence number where the next chunk starts; tracks the receiver's base
    // as long as every chunk is completed before the next one.
    logic [SEQ_W-1:0] next_seq = '0;
    // Withheld sequence number carried across a window change.
    logic [SEQ_W-1:0] missing [$];
    int               eff_window     = WINDOW_MAX;
    int               items_sent     = 0;
    int               settings_done  = 0;

    selective_repeat_window_receiver_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    srwr_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_hdr_count  (hdr_count),
        .o_ack_count  (ack_count),
        .o_dlv_count  (dlv_count),
        .o_peak_burst (peak_burst)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin : out_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_word make_hdr(input logic typ, input logic [SEQ_W-1:0] seq,
                                          input logic [LEN_W-1:0] len, input logic ok,
                                          input logic [OUT_TAG_W-1:0] tag);
        t_in_word h;
        h.req_type    = typ;
        h.seq_num     = seq;
        h.pay_length  = len;
        h.checksum_ok = ok;
        h.payload_tag = tag;
        return h;
    endfunction

    // Well-formed DATA header for one sequence number, lengths biased to the extremes.
    function automatic t_in_word good_hdr(input logic [SEQ_W-1:0] s);
        logic [LEN_W-1:0] len;
        case ($urandom_range(9))
            0:       len = PAYLOAD_MAX;
            1:       len = '0;
            default: len = LEN_W'($urandom_range(int'(PAYLOAD_MAX)));
        endcase
        return make_hdr(REQ_DATA, s, len, 1'b1, OUT_TAG_W'($urandom));
    endfunction

    task automatic shuffle_seqs(ref logic [SEQ_W-1:0] q [$]);
        logic [SEQ_W-1:0] t;
        int               j;
        int               k;
        for (j = q.size() - 1; j > 0; j--) begin
            k    = $urandom_range(j);
            t    = q[j];
            q[j] = q[k];
            q[k] = t;
        end
    endtask

    // Offer one header word and hold it until the block takes it.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every owed word has left and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eff_window = (v == 0) ? 1 : ((int'(v) > WINDOW_MAX) ? WINDOW_MAX : int'(v));
        settings_done++;
    endtask

    task automatic send_end();
        logic [SEQ_W-1:0] s;
        s = ($urandom_range(4) == 0) ? '1 : SEQ_W'($urandom);
        send_word(make_hdr(REQ_END, s, LEN_W'($urandom), 1'($urandom), OUT_TAG_W'($urandom)));
        items_sent++;
        next_seq = '0;
        missing.delete();
    endtask

    // Send n consecutive sequence numbers from next_seq in the given order, with
    // stray headers mixed in, some withheld and resent at the end of the chunk.
    // With keep_gap the first number is withheld and carried, so the rest stay held.
    task automatic send_chunk(input int n, input bit keep_gap, input t_order mode);
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] later [$];
        logic [SEQ_W-1:0] s;
        t_in_word         w;
        bit               withhold;
        int               j;
        for (j = 0; j < n; j++) begin
            order.push_back((mode == ORDER_DOWN) ? next_seq + SEQ_W'(n - 1 - j)
                                                 : next_seq + SEQ_W'(j));
        end
        if (mode == ORDER_SHUFFLE) shuffle_seqs(order);
        for (j = 0; j < n; j++) begin
            s = order[j];
            // stray header the window has to drop
            if ($urandom_range(99) < 15) begin
                w = make_hdr(REQ_DATA, s, LEN_W'($urandom_range(int'(PAYLOAD_MAX))), 1'b0,
                             OUT_TAG_W'($urandom));
                case ($urandom_range(4))
                    0: begin
                        w.seq_num     = SEQ_W'($urandom);
                        w.pay_length  = LEN_W'($urandom);
                        w.checksum_ok = 1'($urandom);
                    end
                    1: begin
                        w.seq_num     = next_seq - 1 - SEQ_W'($urandom_range(40));
                        w.checksum_ok = 1'b1;
                    end
                    2: begin
                        w.seq_num     = next_seq + SEQ_W'(2 * WINDOW_MAX + $urandom_range(40));
                        w.checksum_ok = 1'b1;
                    end
                    3: begin
                        w.pay_length  = LEN_W'(PAYLOAD_MAX + 1 + $urandom_range(585));
                        w.checksum_ok = 1'b1;
                    end
                    default: ;
                endcase
                send_word(w);
            end
            withhold = keep_gap ? (s == next_seq)
                                : (mode != ORDER_DOWN && $urandom_range(99) < 8);
            if (withhold) begin
                later.push_back(s);
            end else begin
                send_word(good_hdr(s));
                items_sent++;
                if ($urandom_range(99) < 6) send_word(good_hdr(s));
            end
        end
        if (keep_gap) begin
            missing = later;
        end else begin
            shuffle_seqs(later);
            foreach (later[k]) begin
                send_word(good_hdr(later[k]));
                items_sent++;
            end
        end
        next_seq = next_seq + SEQ_W'(n);
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] win, input int in_pct, input int out_pct,
                             input bit keep_gap, input bit long_hold);
        int     start;
        int     n;
        int     chunk_no;
        int     pick;
        bit     final_chunk;
        t_order mode;
        write_window(win);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        if (long_hold) hold_requests++;
        // fill the gap left by the previous phase; the held slots release now
        while (missing.size() > 0) begin
            send_word(good_hdr(missing.pop_front()));
            items_sent++;
        end
        start    = items_sent;
        chunk_no = 0;
        while (items_sent - start < PHASE_ITEMS) begin
            n = PHASE_ITEMS - (items_sent - start);
            final_chunk = (n <= eff_window);
            if (n > eff_window) n = eff_window;
            // first chunk descends so a full window releases in one burst
            pick = $urandom_range(3);
            if (chunk_no == 0) mode = ORDER_DOWN;
            else if (pick == 2) mode = ORDER_UP;
            else if (pick == 3) mode = ORDER_DOWN;
            else mode = ORDER_SHUFFLE;
            send_chunk(n, keep_gap && final_chunk, mode);
            chunk_no++;
            if (final_chunk ? !keep_gap : ($urandom_range(2) == 0)) send_end();
            // the withheld number of a gap chunk is never counted, so stop here
            if (final_chunk) break;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed headers at the reset window of 32, base starting at zero.
        send_word(make_hdr(REQ_DATA, 0, '0, 1'b1, '0));                  // in order, base 1
        send_word(make_hdr(REQ_DATA, 1, PAYLOAD_MAX, 1'b1, '1));         // base 2
        send_word(make_hdr(REQ_DATA, 2, LEN_W'(PAYLOAD_MAX + 1), 1'b1, 16'h1234)); // oversized
        send_word(make_hdr(REQ_DATA, 2, '1, 1'b1, '0));                  // oversized, all ones
        send_word(make_hdr(REQ_DATA, 2, 11'd100, 1'b0, 16'h0001));       // bad checksum
        send_word(make_hdr(REQ_DATA, 1, 11'd5, 1'b1, 16'h0002));         // below base
        send_word(make_hdr(REQ_DATA, '1, 11'd5, 1'b1, 16'h0003));        // wraps below base
        send_word(make_hdr(REQ_DATA, 34, 11'd7, 1'b1, 16'h0004));        // just past window
        send_word(make_hdr(REQ_DATA, 33, 11'h555, 1'b1, 16'h5A5A));      // last slot, held
        send_word(make_hdr(REQ_DATA, 33, 11'h2AA, 1'b1, 16'hA5A5));      // duplicate of held
        send_word(make_hdr(REQ_DATA, 3, 11'h2AA, 1'b1, 16'hA5A5));       // held
        send_word(make_hdr(REQ_DATA, 2, PAYLOAD_MAX, 1'b1, 16'hFFFE));   // releases 2 and 3
        send_word(make_hdr(REQ_END, '1, '1, 1'b0, '1));                  // END, bad checksum
        send_word(make_hdr(REQ_DATA, 0, 11'd1, 1'b1, 16'h8000));         // base is zero again
        send_word(make_hdr(REQ_END, 0, '0, 1'b1, '0));
        send_word(make_hdr(REQ_END, 32'h8000_0001, 11'd3, 1'b1, 16'h7FFF));
        items_sent = 16;
        next_seq   = '0;

        // Window settings with their idle patterns. The 63 and 32 phases leave a
        // gap behind, so the next phase starts with slots held under a new window.
        run_phase(6'd1, 0, 0, 1'b0, 1'b0);
        run_phase(6'd63, 59, 0, 1'b1, 1'b0);
        run_phase(6'd0, 0, 59, 1'b0, 1'b0);
        run_phase(6'd5, 17, 17, 1'b0, 1'b0);
        run_phase(6'd32, 0, 0, 1'b1, 1'b1);
        run_phase(6'd17, 59, 0, 1'b0, 1'b0);
        run_phase(6'd33, 0, 59, 1'b0, 1'b0);
        run_phase(WIN_W'($urandom_range(63)), 17, 17, 1'b0, 1'b0);

        drain();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d headers over %0d window settings: %0d acks, %0d deliveries.",
                 hdr_count, settings_done, ack_count, dlv_count);
        $display("Longest burst from one header: %0d words; one long output hold-off.",
                 peak_burst);
        if (fail_count == 0 && pending_words == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
